// ===== rtl/sil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Types and constants shared by the sorted insert list unit and its testbench.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CntW     = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] element;
    logic [PosW-1:0]         position;
    logic [CntW-1:0]         fill;
    logic signed [DataW-1:0] smallest;
    logic signed [DataW-1:0] largest;
    logic                    last;
  } out_t;

endpackage

// ===== rtl/sorted_insert_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list_unit
// Bounded ascending store of signed values with insert and full read-out.
// ----------------------------------------------------------------------------
// The values live in one RAM with a registered read. An insert walks down
// from the top of the list, one read and one write-back per held value that
// is greater than the new one, then writes the new value into the gap; an
// insert into an empty store writes at once, and one into a full store is
// refused. A read streams the list out at one result per cycle. busy_o is
// high while an item is at work; each result is shown for one cycle on out_o
// with out_valid_o and must be taken then, since the receiver cannot stall
// the unit.
module sorted_insert_list_unit
  #(
  parameter int unsigned Capacity = sil_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sil_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          out_valid_o,
  output sil_pkg::out_t out_o
);
  import sil_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_RD_RUN  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         pos_q, pos_d;
  logic                    pend_q, pend_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic signed [DataW-1:0] min_q, min_d;
  logic signed [DataW-1:0] max_q, max_d;
  logic                    valid_q, valid_d;
  out_t                    out_q, out_d;

  logic                    we;
  logic [AddrW-1:0]        waddr, raddr;
  logic [DataW-1:0]        wdata, rdata;
  logic [CntW-1:0]         idx_m1;
  logic                    ins_done;
  logic                    emit;
  logic [1:0]              emit_status;
  logic                    accept;

  sil_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign idx_m1 = idx_q - CntW'(1);
  assign busy_o = (state_q != S_IDLE) || pend_q;
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pend_d      = 1'b0;
    val_d       = val_q;
    min_d       = min_q;
    max_d       = max_q;
    we          = 1'b0;
    waddr       = idx_q[AddrW-1:0];
    wdata       = val_q;
    raddr       = idx_q[AddrW-1:0];
    ins_done    = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = in_i.value;
          if (in_i.op == OP_INSERT) begin
            if (cnt_q >= CntW'(Capacity)) begin
              emit        = 1'b1;
              emit_status = ST_FULL;
            end else if (cnt_q == '0) begin
              we       = 1'b1;
              waddr    = '0;
              wdata    = in_i.value;
              ins_done = 1'b1;
            end else begin
              idx_d   = cnt_q;
              state_d = S_INS_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              emit        = 1'b1;
              emit_status = ST_EMPTY;
            end else begin
              idx_d   = '0;
              state_d = S_RD_RUN;
            end
          end
        end
      end
      S_INS_RD: begin
        raddr   = idx_m1[AddrW-1:0];
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        we = 1'b1;
        if ($signed(rdata) > val_q) begin
          wdata   = rdata;
          idx_d   = idx_m1;
          state_d = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          ins_done = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_INS_PUT: begin
        we       = 1'b1;
        ins_done = 1'b1;
        state_d  = S_IDLE;
      end
      S_RD_RUN: begin
        pend_d = 1'b1;
        pos_d  = idx_q;
        idx_d  = idx_q + CntW'(1);
        if (idx_q + CntW'(1) == cnt_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ins_done) begin
      cnt_d = cnt_q + CntW'(1);
      emit  = 1'b1;
      if (cnt_q == '0) begin
        min_d = val_d;
        max_d = val_d;
      end else begin
        min_d = (val_d < min_q) ? val_d : min_q;
        max_d = (val_d > max_q) ? val_d : max_q;
      end
    end
  end

  always_comb begin
    valid_d = 1'b0;
    out_d   = out_q;
    if (emit || pend_q) begin
      valid_d        = 1'b1;
      out_d.status   = pend_q ? ST_OK : emit_status;
      out_d.element  = pend_q ? $signed(rdata) : '0;
      out_d.position = pend_q ? pos_q[PosW-1:0] : '0;
      out_d.fill     = cnt_d;
      out_d.smallest = (cnt_d != '0) ? min_d : '0;
      out_d.largest  = (cnt_d != '0) ? max_d : '0;
      out_d.last     = pend_q ? (pos_q + CntW'(1) == cnt_q) : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    val_q <= val_d;
    min_q <= min_d;
    max_q <= max_d;
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/sil_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sil_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_insert_list_unit. A short table of directed
// items (empty read, extreme values, duplicates, repeated reads) runs first.
// Random inserts and reads follow, filling the store to capacity and then
// hitting refused inserts and full read-outs. Every transfer out of the unit
// is compared field by field with a typed row or a behavioral model of the sorted store.
// ----------------------------------------------------------------------------
module testbench;
  import sil_pkg::*;

  localparam int unsigned RandItems = 345;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  in_i;
  logic busy_o;
  logic out_valid_o;
  out_t out_o;

  logic signed [DataW-1:0] model_vals [CAPACITY];
  int unsigned             model_count;
  out_t                    pending_outputs [$];
  row_t                    directed_rows [$];
  int unsigned             fail_count;
  int unsigned             gapless_left;
  bit                      gapless;

  sorted_insert_list_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_t mk_in(logic op, logic signed [DataW-1:0] v);
    in_t r;
    r.op    = op;
    r.value = v;
    return r;
  endfunction

  function automatic out_t mk_single(logic [1:0] st, int unsigned n,
                                     logic signed [DataW-1:0] lo,
                                     logic signed [DataW-1:0] hi);
    out_t r;
    r          = '0;
    r.status   = st;
    r.fill     = CntW'(n);
    r.smallest = lo;
    r.largest  = hi;
    r.last     = 1'b1;
    return r;
  endfunction

  // sorted store model, produces every transfer one item causes
  task automatic predict_list_outputs(input in_t item, ref out_t produced[$]);
    int unsigned             i;
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
    out_t                    r;
    bit                      refused;
    refused = (item.op == OP_INSERT) && (model_count >= CAPACITY);
    if (item.op == OP_INSERT && !refused) begin
      i = model_count;
      while (i > 0 && model_vals[i-1] > item.value) begin
        model_vals[i] = model_vals[i-1];
        i--;
      end
      model_vals[i] = item.value;
      model_count++;
    end
    lo = (model_count != 0) ? model_vals[0] : '0;
    hi = (model_count != 0) ? model_vals[model_count-1] : '0;
    if (item.op == OP_INSERT) begin
      produced.push_back(mk_single(refused ? ST_FULL : ST_OK, model_count, lo, hi));
    end else if (model_count == 0) begin
      produced.push_back(mk_single(ST_EMPTY, 0, '0, '0));
    end else begin
      for (int unsigned k = 0; k < model_count; k++) begin
        r          = mk_single(ST_OK, model_count, lo, hi);
        r.element  = model_vals[k];
        r.position = PosW'(k);
        r.last     = (k + 1 == model_count);
        produced.push_back(r);
      end
    end
  endtask

  task automatic send_item(input in_t item, input bit typed, input out_t want);
    int unsigned gap;
    out_t        produced [$];
    if (gapless_left == 0) begin
      gapless_left = $urandom_range(1, 40);
      gapless      = ($urandom_range(0, 2) == 0);
    end
    gapless_left--;
    gap = gapless ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o);
    predict_list_outputs(item, produced);
    if (typed) begin
      pending_outputs.push_back(want);
    end else begin
      foreach (produced[k]) pending_outputs.push_back(produced[k]);
    end
  endtask

  function automatic logic signed [DataW-1:0] draw_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 10)) - 5;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -1;
          default: return 0;
        endcase
      end
      default: begin
        if (model_count == 0) return $urandom;
        return model_vals[$urandom_range(0, model_count - 1)];
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output transfer");
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_o.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_o.status);
          fail_count++;
        end
        if (out_o.element !== want.element) begin
          $error("element expected %0d actual %0d", want.element, out_o.element);
          fail_count++;
        end
        if (out_o.position !== want.position) begin
          $error("position expected %0d actual %0d", want.position, out_o.position);
          fail_count++;
        end
        if (out_o.fill !== want.fill) begin
          $error("fill expected %0d actual %0d", want.fill, out_o.fill);
          fail_count++;
        end
        if (out_o.smallest !== want.smallest) begin
          $error("smallest expected %0d actual %0d", want.smallest, out_o.smallest);
          fail_count++;
        end
        if (out_o.largest !== want.largest) begin
          $error("largest expected %0d actual %0d", want.largest, out_o.largest);
          fail_count++;
        end
        if (out_o.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_o.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t                    row;
    in_t                     item;
    logic signed [DataW-1:0] vmax;
    logic signed [DataW-1:0] vmin;
    vmax         = 32'sh7fff_ffff;
    vmin         = 32'sh8000_0000;
    fail_count   = 0;
    model_count  = 0;
    gapless_left = 0;
    gapless      = 1'b0;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    in_i         <= '0;

    // typed rows: empty read and the first inserts at the extremes
    directed_rows.push_back('{mk_in(OP_READ, 0), 1, mk_single(ST_EMPTY, 0, 0, 0)});
    directed_rows.push_back('{mk_in(OP_INSERT, 0), 1, mk_single(ST_OK, 1, 0, 0)});
    directed_rows.push_back('{mk_in(OP_INSERT, vmax), 1, mk_single(ST_OK, 2, 0, vmax)});
    directed_rows.push_back('{mk_in(OP_INSERT, vmin), 1, mk_single(ST_OK, 3, vmin, vmax)});
    directed_rows.push_back('{mk_in(OP_READ, 0), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, 0), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, -1), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, 1), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, vmax), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, vmin), 0, '0});
    directed_rows.push_back('{mk_in(OP_READ, 0), 0, '0});
    directed_rows.push_back('{mk_in(OP_READ, 32'sh5a5a_5a5a), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, 32'sh5555_5555), 0, '0});
    directed_rows.push_back('{mk_in(OP_INSERT, 32'shaaaa_aaaa), 0, '0});
    directed_rows.push_back('{mk_in(OP_READ, vmax), 0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_item(row.item, row.typed, row.want);
    end

    // fill up with a mix of values, then refused inserts and full read-outs
    for (int unsigned k = 0; k < RandItems; k++) begin
      item.value = draw_value();
      item.op    = ($urandom_range(0, 99) < ((model_count < CAPACITY) ? 25 : 30)) ?
                   OP_READ : OP_INSERT;
      send_item(item, 1'b0, '0);
    end
    start_i <= 1'b0;

    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (pending_outputs.size() != 0) begin
      $error("%0d expected transfers never arrived", pending_outputs.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sorted_insert_list_unit.f =====
rtl/sil_pkg.sv
rtl/sil_ram.sv
rtl/sorted_insert_list_unit.sv
tb/testbench.sv
